### hw/rtl/rste_pkg.sv
// Shared types and constants for the range sum tree engine.
// No dependencies; the walker, top level and checker refer to this package by scoped names.
`timescale 1ns / 1ps

package rste_pkg;

  // Tree geometry: node 1 is the root, leaf p sits at node LEAVES + p.
  localparam int LEAVES  = 1024;
  localparam int LEAF_W  = 10;
  localparam int RANGE_W = 11;
  localparam int DATA_W  = 32;
  localparam int NODE_W  = $clog2(2 * LEAVES);
  // Walk bounds can reach 2 * LEAVES, one past the last node address.
  localparam int BOUND_W = NODE_W + 1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [LEAF_W-1:0]         leaf_index;
    logic [DATA_W-1:0]         delta;
    logic [RANGE_W-1:0]        range_low;
    logic [RANGE_W-1:0]        range_high;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [NODE_W-1:0] raddr_a;
    logic [NODE_W-1:0] raddr_b;
  } ram_req_t;

endpackage

### hw/rtl/rste_node_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// Self-contained; used by the top level to hold the tree nodes.
`timescale 1ns / 1ps

module rste_node_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/rste_walker.sv
// Sequencer that clears the tree after reset and walks it for point adds and range queries.
// Depends on rste_pkg; drives the node RAM through a ram_req_t request.
`timescale 1ns / 1ps

module rste_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  rste_pkg::cmd_t                cmd,
  output logic                          ready,
  input  logic                          res_free,
  output rste_pkg::res_t                res,
  output rste_pkg::ram_req_t            ram_req,
  input  logic [rste_pkg::DATA_W-1:0]   rdata_a,
  input  logic [rste_pkg::DATA_W-1:0]   rdata_b
);

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_ADD_LEAF = 7'b0000100,
    ST_ADD_UP   = 7'b0001000,
    ST_Q_RD     = 7'b0010000,
    ST_Q_ACC    = 7'b0100000,
    ST_Q_DONE   = 7'b1000000
  } state_t;

  state_t                         state, state_next;
  logic [rste_pkg::NODE_W-1:0]    node, node_next;
  logic [rste_pkg::NODE_W-1:0]    clr_addr, clr_addr_next;
  logic [rste_pkg::DATA_W-1:0]    cur, cur_next;
  logic [rste_pkg::DATA_W-1:0]    delta, delta_next;
  logic [rste_pkg::DATA_W-1:0]    acc, acc_next;
  logic [rste_pkg::BOUND_W-1:0]   lo, lo_next;
  logic [rste_pkg::BOUND_W-1:0]   hi, hi_next;
  logic                           use_l, use_l_next;
  logic                           use_r, use_r_next;

  logic [rste_pkg::RANGE_W-1:0]   lo_sat, hi_sat;
  logic [rste_pkg::NODE_W-1:0]    leaf_node;
  logic                           leaf_ok;
  logic [rste_pkg::NODE_W-1:0]    parent;
  logic [rste_pkg::DATA_W-1:0]    up_sum;
  logic [rste_pkg::BOUND_W-1:0]   hi_dec;

  // Bounds beyond the leaf count are clamped to it.
  assign lo_sat = (cmd.range_low > rste_pkg::RANGE_W'(rste_pkg::LEAVES)) ?
                  rste_pkg::RANGE_W'(rste_pkg::LEAVES) : cmd.range_low;
  assign hi_sat = (cmd.range_high > rste_pkg::RANGE_W'(rste_pkg::LEAVES)) ?
                  rste_pkg::RANGE_W'(rste_pkg::LEAVES) : cmd.range_high;

  assign leaf_node = rste_pkg::NODE_W'(rste_pkg::LEAVES) + rste_pkg::NODE_W'(cmd.leaf_index);
  assign leaf_ok   = rste_pkg::NODE_W'(cmd.leaf_index) < rste_pkg::NODE_W'(rste_pkg::LEAVES);
  assign parent    = {1'b0, node[rste_pkg::NODE_W-1:1]};
  assign up_sum    = cur + rdata_a;
  assign hi_dec    = hi - rste_pkg::BOUND_W'(1);

  assign ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    node_next     = node;
    clr_addr_next = clr_addr;
    cur_next      = cur;
    delta_next    = delta;
    acc_next      = acc;
    lo_next       = lo;
    hi_next       = hi;
    use_l_next    = use_l;
    use_r_next    = use_r;
    ram_req       = '0;
    res           = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        clr_addr_next = clr_addr + rste_pkg::NODE_W'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (cmd.mode == rste_pkg::MODE_ADD) begin
            if (leaf_ok) begin
              node_next       = leaf_node;
              delta_next      = cmd.delta;
              ram_req.raddr_a = leaf_node;
              state_next      = ST_ADD_LEAF;
            end
          end else begin
            lo_next  = rste_pkg::BOUND_W'(lo_sat) + rste_pkg::BOUND_W'(rste_pkg::LEAVES);
            hi_next  = rste_pkg::BOUND_W'(hi_sat) + rste_pkg::BOUND_W'(rste_pkg::LEAVES);
            acc_next = '0;
            state_next = (lo_sat < hi_sat) ? ST_Q_RD : ST_Q_DONE;
          end
        end
      end
      ST_ADD_LEAF: begin
        // Leaf word is back: update it and fetch its sibling in the same cycle.
        cur_next        = rdata_a + delta;
        ram_req.we      = 1'b1;
        ram_req.waddr   = node;
        ram_req.wdata   = cur_next;
        ram_req.raddr_a = {node[rste_pkg::NODE_W-1:1], ~node[0]};
        state_next      = ST_ADD_UP;
      end
      ST_ADD_UP: begin
        // The sibling never equals the parent being written, so no forwarding is needed.
        ram_req.we      = 1'b1;
        ram_req.waddr   = parent;
        ram_req.wdata   = up_sum;
        ram_req.raddr_a = {parent[rste_pkg::NODE_W-1:1], ~parent[0]};
        cur_next        = up_sum;
        node_next       = parent;
        if (parent == rste_pkg::NODE_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_Q_RD: begin
        if (lo < hi) begin
          ram_req.raddr_a = lo[rste_pkg::NODE_W-1:0];
          ram_req.raddr_b = hi_dec[rste_pkg::NODE_W-1:0];
          use_l_next      = lo[0];
          use_r_next      = hi[0];
          lo_next         = (lo + rste_pkg::BOUND_W'(lo[0])) >> 1;
          hi_next         = hi >> 1;
          state_next      = ST_Q_ACC;
        end else begin
          state_next = ST_Q_DONE;
        end
      end
      ST_Q_ACC: begin
        acc_next   = acc + (use_l ? rdata_a : '0) + (use_r ? rdata_b : '0);
        state_next = ST_Q_RD;
      end
      ST_Q_DONE: begin
        res.valid = 1'b1;
        res.data  = acc;
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    node  <= node_next;
    cur   <= cur_next;
    delta <= delta_next;
    acc   <= acc_next;
    lo    <= lo_next;
    hi    <= hi_next;
    use_l <= use_l_next;
    use_r <= use_r_next;
  end

endmodule

### hw/rtl/range_sum_tree_engine_unit.sv
// Top level of the range sum tree engine: command port, result register, node RAM, walker.
// Depends on rste_pkg, rste_node_ram and rste_walker.
`timescale 1ns / 1ps

// Point-add / range-sum segment tree over 1024 signed 32-bit leaves, all sums wrapping
// modulo 2^32. A command with mode 0 adds delta to leaf leaf_index and gives no result; mode 1
// returns the sum of leaves in [range_low, range_high), bounds clamped to 1024, and 0 when the
// interval is empty. One command is worked at a time. After reset the node RAM is cleared one
// word per cycle, so cmd_stall stays high until the whole RAM is cleared. A point add then
// does one leaf read-modify-write plus one sibling read and parent write per tree level. A
// query works two steps per level (both bounds read on the RAM's two read ports, then
// accumulated). The result sits in an output register, so the next command is taken while
// it waits on sum_stall.
module range_sum_tree_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic                                 mode,
  input  logic [rste_pkg::LEAF_W-1:0]          leaf_index,
  input  logic signed [rste_pkg::DATA_W-1:0]   delta,
  input  logic [rste_pkg::RANGE_W-1:0]         range_low,
  input  logic [rste_pkg::RANGE_W-1:0]         range_high,
  output logic                                 sum_valid,
  input  logic                                 sum_stall,
  output logic signed [rste_pkg::DATA_W-1:0]   range_sum
);

  rste_pkg::cmd_t             cmd;
  rste_pkg::res_t             res;
  rste_pkg::ram_req_t         ram_req;
  logic                       ready;
  logic                       start;
  logic                       res_free;
  logic [rste_pkg::DATA_W-1:0] rdata_a, rdata_b;

  assign cmd.mode       = mode;
  assign cmd.leaf_index = leaf_index;
  assign cmd.delta      = $unsigned(delta);
  assign cmd.range_low  = range_low;
  assign cmd.range_high = range_high;

  assign cmd_stall = !ready;
  assign start     = cmd_valid && ready;
  assign res_free  = !sum_valid || !sum_stall;

  rste_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .ready    (ready),
    .res_free (res_free),
    .res      (res),
    .ram_req  (ram_req),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b)
  );

  rste_node_ram #(
    .ADDR_W (rste_pkg::NODE_W),
    .DATA_W (rste_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (res.valid && res_free) begin
      sum_valid <= 1'b1;
    end else if (!sum_stall) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_free) begin
      range_sum <= $signed(res.data);
    end
  end

endmodule

### hw/rtl/rste_checker.sv
// Port-level checks for range_sum_tree_engine_unit, attached with a bind statement.
// Depends only on rste_pkg widths and the top level's ports.
`timescale 1ns / 1ps

module rste_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cmd_valid,
  input logic                                 cmd_stall,
  input logic                                 sum_valid,
  input logic                                 sum_stall,
  input logic signed [rste_pkg::DATA_W-1:0]   range_sum
);

  // The clearing pass keeps the command port closed right after reset.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> cmd_stall)
    else $error("command port open right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !sum_valid)
    else $error("result beat present right after reset");

  // Commands are worked one at a time, so an accepted beat closes the port.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("command port still open after a beat was taken");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && sum_stall) |=> (sum_valid && $stable(range_sum)))
    else $error("stalled result beat changed or vanished");

endmodule

bind range_sum_tree_engine_unit rste_checker u_rste_checker (.*);
